[design/pmo_pkg.sv]
// Package for the phase-modulation oscillator: types, constants, sine table.
package pmo_pkg;

  localparam int CHANNELS        = 16;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SINE_SIZE   = 1 << SINE_TABLE_BITS;
  localparam int QUARTER     = SINE_SIZE >> 2;
  localparam int FRAC_BITS   = 32 - SINE_TABLE_BITS;
  localparam int PHASE_DEPTH = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int IDX_W       = (PHASE_DEPTH > 1) ? $clog2(PHASE_DEPTH) : 1;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;
  localparam int SCALE_W = 36;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd5864062014;

  localparam logic REG_RATIO_MODE = 1'b0;
  localparam logic REG_SCALE      = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [31:0] carrier_freq;
    logic signed [31:0] mod_freq;
    logic signed [23:0] mod_index;
    logic signed [23:0] mod_offset;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [3:0]         out_channel;
  } out_word_t;

  typedef struct packed {
    logic               ratio_mode;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATIO,
    ST_RSAT,
    ST_LOOK,
    ST_INTERP,
    ST_SUM,
    ST_MODT,
    ST_MPH,
    ST_CLO,
    ST_CHI,
    ST_CUPD,
    ST_MLO,
    ST_MHI,
    ST_MUPD,
    ST_DONE
  } state_t;

  typedef logic [15:0] qtab_t [0:QUARTER];

  // restoring shift-subtract quotient, table build only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] quarter_sine(input int unsigned k);
    longint unsigned kk;
    longint unsigned x;
    longint unsigned term;
    longint unsigned div;
    longint          sum;
    longint          val;
    kk   = k;
    x    = (kk * HALF_PI_Q30) / QUARTER;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      div  = longint'(2 * n) * longint'(2 * n + 1);
      term = udiv(term, div);
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    val = longint'((longint'(unsigned'(sum)) * 32767 + (64'd1 << 29)) >> 30);
    if (val > 32767) begin
      val = 32767;
    end
    return 16'(val);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QUARTER; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // full-wave table value from the quarter-wave table
  function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]                   q;
    logic [SINE_TABLE_BITS-3:0]   r;
    logic [SINE_TABLE_BITS-2:0]   k;
    logic signed [15:0]           v;
    q = idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
    r = idx[SINE_TABLE_BITS-3:0];
    k = q[0] ? ((SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
    v = signed'(QTAB[k]);
    return q[1] ? -v : v;
  endfunction

endpackage

[design/pmo_mul.sv]
// Shared signed multiplier with registered product.
module pmo_mul (
  input  logic                               clk,
  input  logic signed [pmo_pkg::MUL_W-1:0]   a,
  input  logic signed [pmo_pkg::MUL_W-1:0]   b,
  output logic signed [pmo_pkg::PROD_W-1:0]  prod
);
  import pmo_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[design/pmo_regs.sv]
// APB configuration registers: ratio mode and sample period scale.
module pmo_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmo_pkg::ADDR_W-1:0]    paddr,
  input  logic [pmo_pkg::DATA_W-1:0]    pwdata,
  output logic [pmo_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output pmo_pkg::cfg_t                 cfg
);
  import pmo_pkg::*;

  logic reg_sel;
  logic wr;

  assign reg_sel = paddr[ADDR_W-1];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio_mode <= 1'b0;
      cfg.scale      <= SCALE_RESET;
    end else if (wr) begin
      if (reg_sel == REG_RATIO_MODE) begin
        cfg.ratio_mode <= pwdata[0];
      end else begin
        cfg.scale <= pwdata[SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_SCALE) begin
      prdata = {{(DATA_W-SCALE_W){1'b0}}, cfg.scale};
    end else begin
      prdata = {{(DATA_W-1){1'b0}}, cfg.ratio_mode};
    end
  end

endmodule

[design/phase_modulation_oscillator.sv]
// Phase-modulation sine oscillator top level: sequencer, phase store, output register.
// A word is taken only in ST_IDLE and is finished before the next is taken; ratio mode adds
// ST_RATIO and ST_RSAT, and an absent channel goes straight to ST_DONE. A finished word
// waiting at the output holds the next; one shared 33x33 multiplier serves every
// product in turn, phase steps take two passes each over the 36-bit scale.
// Reset: synchronous; clears all phase accumulators, ratio mode, and loads the default scale.
module phase_modulation_oscillator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  pmo_pkg::in_word_t             sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output pmo_pkg::out_word_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmo_pkg::ADDR_W-1:0]    paddr,
  input  logic [pmo_pkg::DATA_W-1:0]    pwdata,
  output logic [pmo_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import pmo_pkg::*;

  cfg_t   cfg;
  state_t state, state_next;

  in_word_t                    in_reg;
  logic signed [31:0]          modf;
  logic [31:0]                 look_phase;
  logic signed [15:0]          tab_a;
  logic signed [15:0]          tab_b;
  logic [FRAC_BITS-1:0]        frac;
  logic signed [15:0]          s_val;
  logic [31:0]                 step_lo;
  logic                        second;
  logic [31:0]                 carrier_ph [PHASE_DEPTH];
  logic [31:0]                 mod_ph [PHASE_DEPTH];

  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    rat_sh;
  logic signed [16:0]          diff;
  logic                        ch_ok;
  logic                        load_result;
  logic [IDX_W-1:0]            ch_idx;
  logic [IDX_W-1:0]            in_idx;
  logic [SINE_TABLE_BITS-1:0]  tab_idx;

  pmo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pmo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign ch_ok   = {3'b000, sample.channel} < 7'(CHANNELS);
  assign ch_idx  = in_reg.channel[IDX_W-1:0];
  assign in_idx  = sample.channel[IDX_W-1:0];
  assign tab_idx = look_phase[31:FRAC_BITS];
  assign diff    = {tab_b[15], tab_b} - {tab_a[15], tab_a};
  assign rat_sh  = prod >>> 16;
  assign sample_ready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_a       = '0;
    mul_b       = '0;
    load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          if (!ch_ok) begin
            state_next = ST_DONE;
          end else if (cfg.ratio_mode) begin
            state_next = ST_RATIO;
          end else begin
            state_next = ST_LOOK;
          end
        end
      end
      ST_RATIO: begin
        mul_a      = {in_reg.carrier_freq[31], in_reg.carrier_freq};
        mul_b      = {in_reg.mod_freq[31], in_reg.mod_freq};
        state_next = ST_RSAT;
      end
      ST_RSAT:   state_next = ST_LOOK;
      ST_LOOK:   state_next = ST_INTERP;
      ST_INTERP: begin
        mul_a      = {{(MUL_W-17){diff[16]}}, diff};
        mul_b      = {{(MUL_W-FRAC_BITS){1'b0}}, frac};
        state_next = ST_SUM;
      end
      ST_SUM:    state_next = second ? ST_CLO : ST_MODT;
      ST_MODT: begin
        mul_a      = {{(MUL_W-16){s_val[15]}}, s_val};
        mul_b      = {{(MUL_W-24){in_reg.mod_index[23]}}, in_reg.mod_index};
        state_next = ST_MPH;
      end
      ST_MPH:    state_next = ST_LOOK;
      ST_CLO: begin
        mul_a      = {in_reg.carrier_freq[31], in_reg.carrier_freq};
        mul_b      = {1'b0, cfg.scale[31:0]};
        state_next = ST_CHI;
      end
      ST_CHI: begin
        mul_a      = {in_reg.carrier_freq[31], in_reg.carrier_freq};
        mul_b      = {{(MUL_W-SCALE_W+32){1'b0}}, cfg.scale[SCALE_W-1:32]};
        state_next = ST_CUPD;
      end
      ST_CUPD:   state_next = ST_MLO;
      ST_MLO: begin
        mul_a      = {modf[31], modf};
        mul_b      = {1'b0, cfg.scale[31:0]};
        state_next = ST_MHI;
      end
      ST_MHI: begin
        mul_a      = {modf[31], modf};
        mul_b      = {{(MUL_W-SCALE_W+32){1'b0}}, cfg.scale[SCALE_W-1:32]};
        state_next = ST_MUPD;
      end
      ST_MUPD:   state_next = ST_DONE;
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          in_reg     <= sample;
          modf       <= sample.mod_freq;
          look_phase <= mod_ph[in_idx] + {sample.mod_offset[15:0], 16'h0000};
          s_val      <= '0;
        end
      end
      ST_RSAT: begin
        if ((&rat_sh[PROD_W-1:31]) || !(|rat_sh[PROD_W-1:31])) begin
          modf <= rat_sh[31:0];
        end else if (rat_sh[PROD_W-1]) begin
          modf <= 32'sh8000_0000;
        end else begin
          modf <= 32'sh7fff_ffff;
        end
      end
      ST_LOOK: begin
        tab_a <= sine_at(tab_idx);
        tab_b <= sine_at(SINE_TABLE_BITS'(tab_idx + 1'b1));
        frac  <= look_phase[FRAC_BITS-1:0];
      end
      ST_SUM: s_val <= tab_a + prod[FRAC_BITS+15:FRAC_BITS];
      ST_MPH: look_phase <= carrier_ph[ch_idx] + {prod[30:0], 1'b0};
      ST_CHI: step_lo <= prod[63:32];
      ST_MHI: step_lo <= prod[63:32];
      default: ;
    endcase
  end

  // phase accumulators and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PHASE_DEPTH; i++) begin
        carrier_ph[i] <= '0;
        mod_ph[i]     <= '0;
      end
      second       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE && sample_valid) begin
        second <= 1'b0;
      end else if (state == ST_MPH) begin
        second <= 1'b1;
      end
      if (state == ST_CUPD) begin
        carrier_ph[ch_idx] <= carrier_ph[ch_idx] + step_lo + prod[31:0];
      end
      if (state == ST_MUPD) begin
        mod_ph[ch_idx] <= mod_ph[ch_idx] + step_lo + prod[31:0];
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.sample_out  <= s_val;
      result.out_channel <= in_reg.channel;
    end
  end

endmodule

[dv/phase_modulation_oscillator_tb.sv]
// Self-checking testbench for the phase-modulation oscillator: directed table, random words.
module phase_modulation_oscillator_tb;

  localparam int TBITS  = pmo_pkg::SINE_TABLE_BITS;
  localparam int FBITS  = 32 - TBITS;
  localparam int TSIZE  = 1 << TBITS;
  localparam int QSIZE  = TSIZE / 4;
  localparam int NCHAN  = pmo_pkg::CHANNELS;

  localparam logic [pmo_pkg::ADDR_W-1:0] ADDR_RATIO = 4'h0;
  localparam logic [pmo_pkg::ADDR_W-1:0] ADDR_SCALE = 4'h8;

  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 240;
  localparam int SETTLE_CYCLES     = 20;
  localparam int END_CYCLES        = 40;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int MAX_WAIT          = 18;

  typedef struct {
    pmo_pkg::in_word_t  w;
    bit                 known;
    logic signed [15:0] value;
  } dir_row_t;

  typedef struct {
    logic                        ratio;
    logic [pmo_pkg::SCALE_W-1:0] scale;
  } setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  pmo_pkg::in_word_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  pmo_pkg::out_word_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pmo_pkg::ADDR_W-1:0] paddr = '0;
  logic [pmo_pkg::DATA_W-1:0] pwdata = '0;
  logic [pmo_pkg::DATA_W-1:0] prdata;
  logic pready;

  phase_modulation_oscillator i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // oscillator model state
  int                          sine_tab [TSIZE];
  logic [31:0]                 carrier_acc [NCHAN];
  logic [31:0]                 mod_acc [NCHAN];
  logic                        cfg_ratio;
  logic [pmo_pkg::SCALE_W-1:0] cfg_scale;

  pmo_pkg::out_word_t expected_samples [$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  int  idle_cycles = 0;

  function automatic int quarter_wave(int unsigned k);
    longint unsigned kk;
    longint unsigned x;
    longint unsigned t;
    longint unsigned d;
    longint          acc;
    longint          v;
    kk  = k;
    x   = (kk * 64'd1686629713) / QSIZE;
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      d = 64'(2 * n) * 64'(2 * n + 1);
      t = t / d;
      if (n % 2 == 1) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (acc * 32767 + (longint'(1) << 29)) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return int'(v);
  endfunction

  function automatic void build_sine_tab();
    int q;
    int r;
    int v;
    for (int i = 0; i < TSIZE; i++) begin
      q = i / QSIZE;
      r = i % QSIZE;
      v = (q % 2 == 1) ? quarter_wave(QSIZE - r) : quarter_wave(r);
      sine_tab[i] = (q >= 2) ? -v : v;
    end
  endfunction

  function automatic int sine_interp(logic [31:0] ph);
    int     idx;
    longint a;
    longint b;
    longint d;
    idx = int'(ph[31 -: TBITS]);
    a   = sine_tab[idx];
    b   = sine_tab[(idx + 1) % TSIZE];
    d   = (b - a) * longint'(64'(ph[FBITS-1:0]));
    return int'(a + (d >>> FBITS));
  endfunction

  function automatic logic [31:0] phase_advance(longint f);
    logic [63:0] p;
    p = 64'(f) * 64'(cfg_scale);
    return p[63:32];
  endfunction

  function automatic pmo_pkg::out_word_t oscillate(pmo_pkg::in_word_t w);
    pmo_pkg::out_word_t o;
    longint      cf;
    longint      mf;
    longint      s;
    longint      prod;
    logic [31:0] mterm;
    int          ch;
    ch            = int'(w.channel);
    o.out_channel = w.channel;
    if (ch >= NCHAN) begin
      o.sample_out = '0;
      return o;
    end
    cf = longint'(signed'(w.carrier_freq));
    mf = longint'(signed'(w.mod_freq));
    if (cfg_ratio) begin
      mf = (mf * cf) >>> 16;
      if (mf > 64'sd2147483647) begin
        mf = 64'sd2147483647;
      end
      if (mf < -64'sd2147483648) begin
        mf = -64'sd2147483648;
      end
    end
    s     = sine_interp(mod_acc[ch] + {w.mod_offset[15:0], 16'h0000});
    prod  = s * longint'(signed'(w.mod_index));
    mterm = 32'(prod * 2);
    o.sample_out = 16'(sine_interp(carrier_acc[ch] + mterm));
    carrier_acc[ch] = carrier_acc[ch] + phase_advance(cf);
    mod_acc[ch]     = mod_acc[ch] + phase_advance(mf);
    return o;
  endfunction

  function automatic int wait_draw();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [31:0] pick_field(int w);
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? (32'h7FFFFFFF >> (32 - w)) : ~(32'h7FFFFFFF >> (32 - w));
      1: return (32'($urandom_range(0, 20000)) << 16) | 32'(16'($urandom()));
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      default: return $urandom();
    endcase
  endfunction

  function automatic pmo_pkg::in_word_t rand_sample();
    pmo_pkg::in_word_t w;
    w.channel      = 4'($urandom_range(0, 15));
    w.carrier_freq = pick_field(32);
    w.mod_freq     = pick_field(32);
    w.mod_index    = 24'(pick_field(24));
    w.mod_offset   = 24'(pick_field(24));
    return w;
  endfunction

  // called at a clock edge; returns at the edge where the word is taken
  task automatic send_word(pmo_pkg::in_word_t w, bit known, logic signed [15:0] value);
    int gap;
    pmo_pkg::out_word_t o;
    gap = wait_draw();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= w;
    do @(posedge clk); while (sample_ready !== 1'b1);
    o = oscillate(w);
    if (known) begin
      o.sample_out = value;
    end
    expected_samples.push_back(o);
  endtask

  // psel stays high between back-to-back transfers; caller lowers it
  task automatic apb_xfer(input logic wr, input logic [pmo_pkg::ADDR_W-1:0] addr,
                          input logic [pmo_pkg::DATA_W-1:0] wdata,
                          output logic [pmo_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
  endtask

  task automatic set_reg(input logic [pmo_pkg::ADDR_W-1:0] addr,
                         input logic [pmo_pkg::DATA_W-1:0] value);
    logic [pmo_pkg::DATA_W-1:0] rd;
    apb_xfer(1'b1, addr, value, rd);
    if (addr == ADDR_RATIO) begin
      cfg_ratio = value[0];
    end else begin
      cfg_scale = value[pmo_pkg::SCALE_W-1:0];
    end
    apb_xfer(1'b0, addr, '0, rd);
    if (rd !== value) begin
      $display("%0t: readback of reg %0h expected %0h actual %0h", $time, addr, value, rd);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
                 (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall once a word is offered, then check
  initial begin
    int stall;
    pmo_pkg::out_word_t got;
    pmo_pkg::out_word_t want;
    wait (rst == 1'b0);
    forever begin
      stall = wait_draw();
      if (stall == 0) begin
        result_ready <= 1'b1;
        do @(posedge clk); while (result_valid !== 1'b1);
      end else begin
        result_ready <= 1'b0;
        do @(posedge clk); while (result_valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
        result_ready <= 1'b1;
        do @(posedge clk); while (result_valid !== 1'b1);
      end
      got = result;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected word expected none actual %0d/%0d", $time,
                 got.sample_out, got.out_channel);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (got.sample_out !== want.sample_out) begin
          $display("%0t: sample_out expected %0d actual %0d", $time,
                   want.sample_out, got.sample_out);
          mismatches++;
        end
        if (got.out_channel !== want.out_channel) begin
          $display("%0t: out_channel expected %0d actual %0d", $time,
                   want.out_channel, got.out_channel);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [13];
    setting_t settings [NUM_SETTINGS];

    // fresh channel starts at phase 0; with zero offset or zero mod index its first sample is 0
    dir_rows = '{
      '{'{4'd0,  32'h00000000, 32'h00000000, 24'h000000, 24'h000000}, 1'b1, 16'sd0},
      '{'{4'd1,  32'h7FFFFFFF, 32'h7FFFFFFF, 24'h7FFFFF, 24'h000000}, 1'b1, 16'sd0},
      '{'{4'd2,  32'h80000000, 32'h80000000, 24'h800000, 24'h000000}, 1'b1, 16'sd0},
      '{'{4'd3,  32'h00010000, 32'h00010000, 24'h000000, 24'h004000}, 1'b1, 16'sd0},
      '{'{4'd8,  32'h00000000, 32'h00000000, 24'h000000, 24'h7FFFFF}, 1'b1, 16'sd0},
      '{'{4'd4,  32'h00000000, 32'h00000000, 24'h004000, 24'h004000}, 1'b0, 16'sd0},
      '{'{4'd5,  32'h01B80000, 32'h00DC0000, 24'h7FFFFF, 24'hFFC000}, 1'b0, 16'sd0},
      '{'{4'd6,  32'hFFFFFFFF, 32'h00000001, 24'h800000, 24'h7FFFFF}, 1'b0, 16'sd0},
      '{'{4'd15, 32'h7FFFFFFF, 32'h80000000, 24'h7FFFFF, 24'h800000}, 1'b0, 16'sd0},
      '{'{4'd1,  32'h7FFFFFFF, 32'h7FFFFFFF, 24'h7FFFFF, 24'h000000}, 1'b0, 16'sd0},
      '{'{4'd2,  32'h80000000, 32'h80000000, 24'h800000, 24'h000000}, 1'b0, 16'sd0},
      '{'{4'd7,  32'h00000001, 32'hFFFFFFFF, 24'h000001, 24'hFFFFFF}, 1'b0, 16'sd0},
      '{'{4'd0,  32'h40000000, 32'hC0000000, 24'h010000, 24'h008000}, 1'b0, 16'sd0}
    };

    settings[0] = '{1'b0, pmo_pkg::SCALE_RESET};
    settings[1] = '{1'b0, 36'hF_FFFF_FFFF};
    settings[2] = '{1'b1, 36'd1};
    settings[3] = '{1'b1, pmo_pkg::SCALE_RESET};
    settings[4] = '{1'b0, {4'($urandom()), 32'($urandom())} | 36'd1};
    settings[5] = '{1'b1, 36'hF_FFFF_FFFF};
    settings[6] = '{1'b0, 36'd1};
    settings[7] = '{1'b1, {4'($urandom()), 32'($urandom())} | 36'd1};

    build_sine_tab();
    foreach (carrier_acc[i]) begin
      carrier_acc[i] = '0;
      mod_acc[i]     = '0;
    end
    cfg_ratio = 1'b0;
    cfg_scale = pmo_pkg::SCALE_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      if (p > 0) begin
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        set_reg(ADDR_RATIO, 64'(settings[p].ratio));
        set_reg(ADDR_SCALE, 64'(settings[p].scale));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
      end else begin
        foreach (dir_rows[i]) begin
          send_word(dir_rows[i].w, dir_rows[i].known, dir_rows[i].value);
        end
      end
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if ($urandom_range(0, 99) == 0) begin
          no_idle = !no_idle;
        end
        send_word(rand_sample(), 1'b0, 16'sd0);
      end
      sample_valid <= 1'b0;
    end

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/pmo_pkg.sv
design/pmo_mul.sv
design/pmo_regs.sv
design/phase_modulation_oscillator.sv
dv/phase_modulation_oscillator_tb.sv
